// ===== rtl/hex_float_literal_parser_top_assert.svh =====
// ----------------------------------------------------------------------------
// hex float literal parser assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef HEX_FLOAT_LITERAL_PARSER_TOP_ASSERT_SVH
`define HEX_FLOAT_LITERAL_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define HFLP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HFLP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hflp_pkg.sv =====
// ----------------------------------------------------------------------------
// hflp_pkg
// shared types and codes of the hex float literal parser
// ----------------------------------------------------------------------------
package hflp_pkg;

	// size codes
	localparam logic [1:0] SIZE_DOUBLE = 2'd0;
	localparam logic [1:0] SIZE_FLOAT  = 2'd1;
	localparam logic [1:0] SIZE_LONG   = 2'd2;

	// accumulated exponent limits (17 bit signed)
	localparam logic signed [17:0] ACC_MAX = 18'sd65535;
	localparam logic signed [17:0] ACC_MIN = -18'sd65536;

	// result exponent limits (16 bit signed)
	localparam logic signed [17:0] RES_MAX = 18'sd32767;
	localparam logic signed [17:0] RES_MIN = -18'sd32768;

	// parsed literal as handed from the scanner to the finisher
	typedef struct packed {
		logic [63:0]        mant;
		logic signed [16:0] expo;
		logic [15:0]        pow;
		logic               neg;
		logic [1:0]         size;
		logic               sat;
		logic               seen;
	} rec_t;

endpackage

// ===== rtl/hflp_char_if.sv =====
// ----------------------------------------------------------------------------
// hflp_char_if
// character channel: one literal character per word
// ----------------------------------------------------------------------------
interface hflp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       final_char;

	modport source (output valid, output char_code, output final_char, input ready);
	modport sink (input valid, input char_code, input final_char, output ready);
endinterface

// ===== rtl/hflp_result_if.sv =====
// ----------------------------------------------------------------------------
// hflp_result_if
// result channel: one parsed literal per word
// ----------------------------------------------------------------------------
interface hflp_result_if;
	logic               valid;
	logic               ready;
	logic [63:0]        mantissa;
	logic signed [15:0] binary_exponent;
	logic [1:0]         size_code;
	logic               exponent_saturated;

	modport source (output valid, output mantissa, output binary_exponent,
		output size_code, output exponent_saturated, input ready);
	modport sink (input valid, input mantissa, input binary_exponent,
		input size_code, input exponent_saturated, output ready);
endinterface

// ===== rtl/hflp_scan.sv =====
// ----------------------------------------------------------------------------
// hflp_scan
// per-character parse state update and capture of the finished literal
// ----------------------------------------------------------------------------
module hflp_scan #(
	parameter int MANT_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	hflp_char_if.sink         chr,
	output hflp_pkg::rec_t    rec_s1,
	output logic              rec_valid_s1,
	input  logic              rec_ready
);

	`include "hex_float_literal_parser_top_assert.svh"

	typedef enum logic [4:0] {
		PH_WHOLE   = 5'b00001,
		PH_FRAC    = 5'b00010,
		PH_EXPSIGN = 5'b00100,
		PH_EXPDIG  = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	typedef struct packed {
		logic signed [16:0] expo;
		logic               sat;
	} step_t;

	localparam logic [7:0]  CH_DOT   = 8'h2e;
	localparam logic [7:0]  CH_LP    = 8'h70;
	localparam logic [7:0]  CH_UP    = 8'h50;
	localparam logic [7:0]  CH_MINUS = 8'h2d;
	localparam logic [7:0]  CH_PLUS  = 8'h2b;
	localparam logic [7:0]  CH_LF    = 8'h66;
	localparam logic [7:0]  CH_UF    = 8'h46;
	localparam logic [7:0]  CH_LL    = 8'h6c;
	localparam logic [7:0]  CH_UL    = 8'h4c;
	localparam logic [7:0]  MANT_LIM = 8'(MANT_BITS);
	localparam logic [63:0] KEEP     = ~({64{1'b1}} >> MANT_BITS);

	// saturating exponent step
	function automatic step_t exp_step(input logic signed [16:0] e,
		input logic signed [3:0] d);
		logic signed [17:0] s;
		step_t r;
		s = 18'(e) + 18'(d);
		r.sat = 1'b0;
		if (s > hflp_pkg::ACC_MAX) begin
			r.expo = 17'(hflp_pkg::ACC_MAX);
			r.sat  = 1'b1;
		end else if (s < hflp_pkg::ACC_MIN) begin
			r.expo = 17'(hflp_pkg::ACC_MIN);
			r.sat  = 1'b1;
		end else begin
			r.expo = 17'(s);
		end
		return r;
	endfunction

	phase_t         phase_q, phase_n;
	hflp_pkg::rec_t st_q, st_n;
	logic [6:0]     bf_q, bf_n;

	logic [7:0]  c;
	logic        is_hex, is_dec, frac;
	logic [3:0]  nib;
	logic [1:0]  lz;
	logic [63:0] nib_top;
	logic [7:0]  bf_sum;
	logic [19:0] pow_calc;
	step_t       stp;
	logic        fire;

	hflp_pkg::rec_t dg_st;
	logic [6:0]     dg_bf;

	assign c      = chr.char_code;
	assign fire   = chr.valid && chr.ready;
	assign frac   = (phase_q == PH_FRAC);
	assign is_dec = (c >= 8'h30) && (c <= 8'h39);
	assign nib_top = {nib, 60'd0};
	assign bf_sum  = {1'b0, bf_q} + 8'd4;
	assign chr.ready = !rec_valid_s1 || rec_ready;

	// hex digit decode
	always_comb begin
		is_hex = 1'b1;
		nib    = c[3:0];
		if (is_dec) begin
			nib = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			nib = c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	// leading zeros of the nibble
	always_comb begin
		priority if (nib[3]) lz = 2'd0;
		else if (nib[2])     lz = 2'd1;
		else if (nib[1])     lz = 2'd2;
		else                 lz = 2'd3;
	end

	// one digit: four mantissa bits and the exponent count
	always_comb begin
		dg_st = st_q;
		dg_bf = bf_q;
		stp   = exp_step(st_q.expo, 4'sd4);
		if (!st_q.seen) begin
			if (nib == 4'd0) begin
				stp = exp_step(st_q.expo, -4'sd4);
				if (frac) begin
					dg_st.expo = stp.expo;
					dg_st.sat  = st_q.sat | stp.sat;
				end
			end else begin
				dg_st.seen = 1'b1;
				dg_st.mant = (nib_top << lz) & KEEP;
				dg_bf      = 7'd4 - 7'(lz);
				if (frac) begin
					// first one counts as a fraction bit too
					stp        = exp_step(st_q.expo, $signed(~{2'b00, lz}));
					dg_st.expo = stp.expo;
					dg_st.sat  = st_q.sat | stp.sat;
				end else begin
					dg_st.expo = 17'sd3 - $signed(17'(lz));
				end
			end
		end else begin
			dg_st.mant = st_q.mant | ((nib_top >> bf_q) & KEEP);
			dg_bf      = (bf_sum > MANT_LIM) ? 7'(MANT_LIM) : 7'(bf_sum);
			if (!frac) begin
				dg_st.expo = stp.expo;
				dg_st.sat  = st_q.sat | stp.sat;
			end
		end
	end

	assign pow_calc = ({4'd0, st_q.pow} << 3) + ({4'd0, st_q.pow} << 1) + 20'(c[3:0]);

	always_comb begin
		st_n    = st_q;
		bf_n    = bf_q;
		phase_n = phase_q;
		unique case (phase_q)
			PH_WHOLE, PH_FRAC: begin
				if (is_hex) begin
					st_n = dg_st;
					bf_n = dg_bf;
				end else if (c == CH_DOT && phase_q == PH_WHOLE) begin
					phase_n = PH_FRAC;
				end else if (c == CH_LP || c == CH_UP) begin
					phase_n = PH_EXPSIGN;
				end else begin
					phase_n = PH_DONE;
					if (c == CH_LL || c == CH_UL) st_n.size = hflp_pkg::SIZE_LONG;
				end
			end
			PH_EXPSIGN, PH_EXPDIG: begin
				if (c == CH_MINUS && phase_q == PH_EXPSIGN) begin
					st_n.neg = 1'b1;
					phase_n  = PH_EXPDIG;
				end else if (c == CH_PLUS && phase_q == PH_EXPSIGN) begin
					phase_n = PH_EXPDIG;
				end else if (is_dec) begin
					phase_n = PH_EXPDIG;
					if (pow_calc > 20'd65535) begin
						st_n.pow = 16'hffff;
						st_n.sat = 1'b1;
					end else begin
						st_n.pow = 16'(pow_calc);
					end
				end else begin
					phase_n = PH_DONE;
					if (c == CH_LF || c == CH_UF) st_n.size = hflp_pkg::SIZE_FLOAT;
					else if (c == CH_LL || c == CH_UL) st_n.size = hflp_pkg::SIZE_LONG;
				end
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WHOLE;
			st_q         <= '0;
			bf_q         <= '0;
			rec_valid_s1 <= 1'b0;
		end else begin
			if (fire && chr.final_char) begin
				phase_q      <= PH_WHOLE;
				st_q         <= '0;
				bf_q         <= '0;
				rec_valid_s1 <= 1'b1;
			end else begin
				if (fire) begin
					phase_q <= phase_n;
					st_q    <= st_n;
					bf_q    <= bf_n;
				end
				if (rec_ready) rec_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && chr.final_char) rec_s1 <= st_n;
	end

	`HFLP_ASSERT_IMP(a_lead_one, st_q.seen, st_q.mant[63], "leading one missing")
	`HFLP_ASSERT_IMP(a_zero_empty, !st_q.seen, st_q.mant == 64'd0 && bf_q == 7'd0,
		"bits taken before the leading one")
	`HFLP_ASSERT_NXT(a_restart, fire && chr.final_char,
		phase_q == PH_WHOLE && !st_q.seen && rec_valid_s1, "no restart after final word")

endmodule

// ===== rtl/hflp_finish.sv =====
// ----------------------------------------------------------------------------
// hflp_finish
// applies the p exponent, clamps, and holds the result word
// ----------------------------------------------------------------------------
module hflp_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  hflp_pkg::rec_t rec_s1,
	input  logic           rec_valid_s1,
	output logic           rec_ready,
	hflp_result_if.source  res
);

	`include "hex_float_literal_parser_top_assert.svh"

	logic signed [17:0] e_sum;
	logic signed [15:0] e_out;
	logic               e_sat;
	logic               take;
	logic               valid_q;

	assign rec_ready = !valid_q || res.ready;
	assign take      = rec_valid_s1 && rec_ready;
	assign res.valid = valid_q;

	always_comb begin
		e_sum = rec_s1.neg ? 18'(rec_s1.expo) - $signed({2'b00, rec_s1.pow})
		                   : 18'(rec_s1.expo) + $signed({2'b00, rec_s1.pow});
		e_sat = rec_s1.sat;
		if (e_sum > hflp_pkg::RES_MAX) begin
			e_out = 16'(hflp_pkg::RES_MAX);
			e_sat = 1'b1;
		end else if (e_sum < hflp_pkg::RES_MIN) begin
			e_out = 16'(hflp_pkg::RES_MIN);
			e_sat = 1'b1;
		end else begin
			e_out = 16'(e_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res.size_code <= rec_s1.size;
			if (rec_s1.seen) begin
				res.mantissa           <= rec_s1.mant;
				res.binary_exponent    <= e_out;
				res.exponent_saturated <= e_sat;
			end else begin
				// zero value
				res.mantissa           <= '0;
				res.binary_exponent    <= '0;
				res.exponent_saturated <= 1'b0;
			end
		end
	end

	`HFLP_ASSERT_IMP(a_zero_word, valid_q && res.mantissa == 64'd0,
		res.binary_exponent == 16'sd0 && !res.exponent_saturated, "zero with exponent")
	`HFLP_ASSERT_IMP(a_norm_word, valid_q && res.mantissa != 64'd0, res.mantissa[63],
		"mantissa not normalized")

endmodule

// ===== rtl/hex_float_literal_parser_top.sv =====
// ----------------------------------------------------------------------------
// hex_float_literal_parser_top
// hex floating literal parser: characters after 0x in, normalized value out
// ----------------------------------------------------------------------------
// takes one character word per cycle on chr while ready is high (digits,
// optional '.', optional p/P with sign and decimal power, optional f/F/l/L
// suffix; f/F is a digit until the power marker). the word flagged final_char
// closes the literal and the parser restarts for the next one. res carries the
// first MANT_BITS significant bits, truncated, with the leading one at bit 63,
// the power of two of bit 63, the size code and a flag raised when the running
// exponent, the power value or the final 16 bit exponent clamped. zero gives
// mantissa 0 and exponent 0. an unexpected character stops parsing; later
// characters up to the final one are ignored. the scanner updates the parse
// state with each character taken. its capture register loads when the final
// character is taken, and the finisher's output register loads from it once
// the output register is empty or its word is accepted, so the result word
// passes through both registers. characters keep flowing while a result
// waits, stalling only when both the capture and the output register are full.
// ----------------------------------------------------------------------------
module hex_float_literal_parser_top #(
	parameter int MANT_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	hflp_char_if.sink     chr,
	hflp_result_if.source res
);

	// literal handed from scanner to finisher
	hflp_pkg::rec_t rec_s1;
	logic           rec_valid_s1;
	logic           rec_ready;

	// character scanner, keeps the running parse state
	hflp_scan #(
		.MANT_BITS (MANT_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.chr          (chr),
		.rec_s1       (rec_s1),
		.rec_valid_s1 (rec_valid_s1),
		.rec_ready    (rec_ready)
	);

	// exponent combine, clamp and output register
	hflp_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_s1       (rec_s1),
		.rec_valid_s1 (rec_valid_s1),
		.rec_ready    (rec_ready),
		.res          (res)
	);

endmodule
